// ===== rtl/core/wpid_pkg.sv =====
// package for the windowed pid controller: register indexes, widths, shared types
package wpid_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MS_W = 16;
    localparam int unsigned INT_W = 48;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned TDATA_W = 184;
    localparam int unsigned MUL_A_W = 48;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned PROD_W = 80;
    localparam int unsigned DIV_N_W = 49;
    localparam int unsigned DIV_D_W = 17;
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef enum logic [2:0] {
        REG_GAIN_P = 3'd0,
        REG_GAIN_I = 3'd1,
        REG_GAIN_D = 3'd2,
        REG_GAIN_F = 3'd3,
        REG_IWIN_LO = 3'd4,
        REG_IWIN_HI = 3'd5,
        REG_DWIN_LO = 3'd6,
        REG_DWIN_HI = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

// ===== rtl/core/windowed_pid_controller_top.sv =====
// top level of the windowed pid controller
// Each item is one pid update and yields one drive item. The update runs in a
// sequencer over a shared bit-serial multiplier (one bit per cycle) and a
// bit-serial divider (one bit per cycle): two divides and five multiplies.
// One item is in work at a time; the next is taken once the previous drive item
// has been accepted.
module windowed_pid_controller_top
    import wpid_pkg::*;
#(
    parameter logic signed [31:0] P_WINDOW_LOW = 32'sh8000_0000,
    parameter logic signed [31:0] P_WINDOW_HIGH = 32'sh7fff_ffff
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, setpoint, measurement, given_error, elapsed_ms, out_min, out_max,
    // one_direction, zero pad
    input  logic [TDATA_W-1:0]   s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // drive
    output logic [DATA_W-1:0]    m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] TERM_LIM = PROD_W'(64'sd1152921504606846976);
    localparam logic signed [INT_W:0] S48_MAX = {2'b00, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W:0] S48_MIN = {2'b11, {(INT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_DDIV, ST_DWAIT, ST_IDIV, ST_IWAIT,
        ST_MUL, ST_MWAIT, ST_SUM, ST_OUT
    } state_t;

    logic [DATA_W-1:0] cfg_reg [8];
    state_t state_reg;
    logic [2:0] mstep_reg;
    logic opc_reg, dir_reg;
    logic signed [31:0] sp_reg, meas_reg, given_reg, lo_reg, hi_reg;
    logic [MS_W-1:0] ms_reg;
    logic signed [31:0] err_reg, perr_reg, deriv_reg, prev_err_reg, prev_sp_reg;
    logic signed [INT_W-1:0] isum_reg;
    logic d_in_reg, i_in_reg;
    logic signed [PROD_W-1:0] tot_reg;
    logic signed [PROD_W-1:0] ihi_reg;
    logic m_tvalid_reg;
    logic [DATA_W-1:0] drive_reg;

    unit_ctl_t mul_ctl, div_ctl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIV_N_W-1:0] div_n, div_q;
    logic [DIV_D_W-1:0] div_d;

    logic wr_en;
    logic signed [32:0] diff;
    logic signed [31:0] err_c;
    logic signed [31:0] ilo;
    logic signed [PROD_W-1:0] fl;
    logic signed [INT_W:0] isum_new;
    logic signed [PROD_W-1:0] iterm;

    assign mul_ctl.busy = 1'b0;
    assign div_ctl.busy = 1'b0;
    assign wr_en = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'b00) ? cfg_reg[paddr[4:2]] : '0;
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = drive_reg;

    assign diff = 33'(sp_reg) - 33'(meas_reg);
    always_comb begin
        if (opc_reg) begin
            err_c = given_reg;
        end else if (diff > 33'(S32_MAX)) begin
            err_c = 32'(S32_MAX);
        end else if (diff < 33'(S32_MIN)) begin
            err_c = 32'(S32_MIN);
        end else begin
            err_c = 32'(diff);
        end
    end

    assign ilo = {16'd0, isum_reg[15:0]};
    assign fl = mul_p >>> 16;
    assign isum_new = (INT_W+1)'(isum_reg) + (INT_W+1)'(div_q);

    always_comb begin
        div_n = '0;
        div_d = {1'b0, ms_reg};
        if (state_reg == ST_DDIV) begin
            div_n = DIV_N_W'((33'(err_reg) - 33'(prev_err_reg)) * 43'sd1000);
        end else begin
            div_n = DIV_N_W'(err_reg) * DIV_N_W'(ms_reg);
            div_d = DIV_D_W'(MS_PER_S);
        end
    end

    always_comb begin
        mul_a = MUL_A_W'(perr_reg);
        mul_b = cfg_reg[REG_GAIN_P];
        case (mstep_reg)
            3'd0: begin
                mul_a = MUL_A_W'(perr_reg);
                mul_b = cfg_reg[REG_GAIN_P];
            end
            3'd1: begin
                mul_a = MUL_A_W'(isum_reg >>> 16);
                mul_b = cfg_reg[REG_GAIN_I];
            end
            3'd2: begin
                mul_a = MUL_A_W'(ilo);
                mul_b = cfg_reg[REG_GAIN_I];
            end
            3'd3: begin
                mul_a = MUL_A_W'(deriv_reg);
                mul_b = cfg_reg[REG_GAIN_D];
            end
            default: begin
                mul_a = MUL_A_W'(sp_reg);
                mul_b = cfg_reg[REG_GAIN_F];
            end
        endcase
    end

    always_comb begin
        iterm = ihi_reg + fl;
        if (iterm > TERM_LIM) begin
            iterm = TERM_LIM;
        end else if (iterm < -TERM_LIM) begin
            iterm = -TERM_LIM;
        end
    end

    assign mul_ctl.start = (state_reg == ST_MUL);
    assign div_ctl.start = (state_reg == ST_DDIV) || (state_reg == ST_IDIV);

    wpid_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_ctl.start),
        .a(mul_a), .b(mul_b), .done(mul_ctl.done), .prod(mul_p)
    );

    wpid_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_ctl.start),
        .num(div_n), .den(div_d), .done(div_ctl.done), .quo(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mstep_reg <= '0;
            isum_reg <= '0;
            prev_err_reg <= '0;
            prev_sp_reg <= '0;
            cfg_reg[0] <= '0;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= '0;
            cfg_reg[3] <= '0;
            cfg_reg[4] <= 32'h8000_0000;
            cfg_reg[5] <= 32'h7fff_ffff;
            cfg_reg[6] <= 32'h8000_0000;
            cfg_reg[7] <= 32'h7fff_ffff;
        end else begin
            if (wr_en && paddr[1:0] == 2'b00) begin
                cfg_reg[paddr[4:2]] <= pwdata;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        opc_reg <= s_tdata[0];
                        sp_reg <= s_tdata[32:1];
                        meas_reg <= s_tdata[64:33];
                        given_reg <= s_tdata[96:65];
                        ms_reg <= s_tdata[112:97];
                        lo_reg <= s_tdata[144:113];
                        hi_reg <= s_tdata[176:145];
                        dir_reg <= s_tdata[177];
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (sp_reg != prev_sp_reg) begin
                        isum_reg <= '0;
                        prev_sp_reg <= sp_reg;
                    end
                    err_reg <= err_c;
                    d_in_reg <= (err_c > $signed(cfg_reg[REG_DWIN_LO]))
                        && (err_c < $signed(cfg_reg[REG_DWIN_HI])) && (ms_reg != '0);
                    i_in_reg <= (err_c > $signed(cfg_reg[REG_IWIN_LO]))
                        && (err_c < $signed(cfg_reg[REG_IWIN_HI]));
                    perr_reg <= (err_c < P_WINDOW_LOW || err_c > P_WINDOW_HIGH) ? '0 : err_c;
                    state_reg <= ST_DDIV;
                end
                ST_DDIV: begin
                    state_reg <= d_in_reg ? ST_DWAIT : ST_IDIV;
                    if (!d_in_reg) begin
                        deriv_reg <= '0;
                        prev_err_reg <= err_reg;
                    end
                end
                ST_DWAIT: begin
                    if (div_ctl.done) begin
                        if (64'(div_q) > S32_MAX) begin
                            deriv_reg <= 32'(S32_MAX);
                        end else if (64'(div_q) < S32_MIN) begin
                            deriv_reg <= 32'(S32_MIN);
                        end else begin
                            deriv_reg <= 32'(div_q);
                        end
                        prev_err_reg <= err_reg;
                        state_reg <= ST_IDIV;
                    end
                end
                ST_IDIV: begin
                    state_reg <= ST_IWAIT;
                end
                ST_IWAIT: begin
                    if (div_ctl.done) begin
                        if (!i_in_reg) begin
                            isum_reg <= '0;
                        end else if (isum_new > S48_MAX) begin
                            isum_reg <= INT_W'(S48_MAX);
                        end else if (isum_new < S48_MIN) begin
                            isum_reg <= INT_W'(S48_MIN);
                        end else begin
                            isum_reg <= INT_W'(isum_new);
                        end
                        mstep_reg <= '0;
                        tot_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (mul_ctl.done) begin
                        case (mstep_reg)
                            3'd1: ihi_reg <= mul_p;
                            3'd2: tot_reg <= tot_reg + iterm;
                            default: tot_reg <= tot_reg + fl;
                        endcase
                        if (mstep_reg == 3'd4) begin
                            state_reg <= ST_SUM;
                        end else begin
                            mstep_reg <= mstep_reg + 3'd1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_SUM: begin
                    if (tot_reg > PROD_W'(hi_reg)) begin
                        tot_reg <= PROD_W'(hi_reg);
                    end else if (tot_reg < PROD_W'(lo_reg)) begin
                        tot_reg <= PROD_W'(lo_reg);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg) begin
                        drive_reg <= (dir_reg && tot_reg <= 0) ? '0 : 32'(tot_reg);
                        m_tvalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/wpid_mul.sv =====
// bit-serial signed multiplier, one multiplier bit per cycle
module wpid_mul
    import wpid_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic                       done,
    output logic signed [PROD_W-1:0]   prod
);

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MUL_B_W-1:0] mplier_reg, mplier_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    always_comb begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            mcand_next = PROD_W'(a);
            mplier_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // top bit of the multiplier carries negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'(MUL_B_W - 1)) begin
                    acc_next = acc_reg - mcand_reg;
                end else begin
                    acc_next = acc_reg + mcand_reg;
                end
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(MUL_B_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/wpid_div.sv =====
// restoring divider on magnitudes, one quotient bit per cycle, truncating toward zero
module wpid_div
    import wpid_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [DIV_N_W-1:0]  num,
    input  logic [DIV_D_W-1:0]         den,
    output logic                       done,
    output logic signed [DIV_N_W-1:0]  quo
);

    logic [DIV_N_W-1:0] q_reg, q_next;
    logic [DIV_D_W:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DIV_D_W:0] trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DIV_D_W-1:0], q_reg[DIV_N_W-1]};
        if (start) begin
            q_next = num[DIV_N_W-1] ? DIV_N_W'(-num) : num;
            neg_next = num[DIV_N_W-1];
            rem_next = '0;
            den_next = den;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo = neg_reg ? DIV_N_W'(-q_reg) : q_reg;

endmodule

// ===== rtl/core/wpid_checker.sv =====
// port-level checker for the windowed pid controller, bound to the top level
module wpid_port_checker
    import wpid_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [DATA_W-1:0]   m_tdata,
    input logic                pready
);

    a_no_accept_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");

    a_no_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready) else $error("pready low");

endmodule

bind windowed_pid_controller_top wpid_port_checker u_wpid_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
